FILE: src/jsp_pkg.sv
package jsp_pkg;

   typedef enum logic [2:0] {
      OP_BUTTONS      = 3'd0,
      OP_RX_BYTE      = 3'd1,
      OP_TX_SLOT      = 3'd2,
      OP_REQ_TIMEOUT  = 3'd3,
      OP_IDLE_TIMEOUT = 3'd4,
      OP_SELECT       = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP,
      ST_PUSH,
      ST_POST,
      ST_DONE
   } state_type;

   localparam int NUM_SLOTS = 7;

   typedef struct packed {
      logic [NUM_SLOTS-1:0][7:0] bytes;
      logic [NUM_SLOTS-1:0]      mask;
   } slots_type;

   typedef struct packed {
      logic write;
      logic overflow;
      logic was_empty;
   } push_res_type;

   localparam logic [11:0] GRP_DIR   = 12'h00F;
   localparam logic [11:0] GRP_COLOR = 12'h0F0;
   localparam logic [11:0] GRP_KEY   = 12'hF00;

   localparam logic [7:0] DIR_UP      = 8'h87;
   localparam logic [7:0] DIR_DOWN    = 8'h8F;
   localparam logic [7:0] DIR_VMID    = 8'h80;
   localparam logic [7:0] DIR_LEFT    = 8'hCF;
   localparam logic [7:0] DIR_RIGHT   = 8'hC7;
   localparam logic [7:0] DIR_HMID    = 8'hC0;
   localparam logic [7:0] COLOR_BASE  = 8'h90;
   localparam logic [7:0] KEY_NONE    = 8'hA0;
   localparam logic [7:0] KEY_BASE    = 8'hA0;
   localparam logic [7:0] CSUM_XOR    = 8'hB5;
   localparam logic [7:0] LINK_RESET  = 8'h55;
   localparam logic [3:0] RX_HS_FIRST = 4'h7;
   localparam logic [3:0] RX_HS_NEXT  = 4'hB;
   localparam logic [3:0] RX_LED      = 4'h6;

   function automatic slots_type encode_slots(input logic [11:0] grp, input logic [11:0] val);
      slots_type s;
      s = '0;
      if ((grp & GRP_DIR) != 12'd0) begin
         s.mask[0]  = 1'b1;
         s.mask[1]  = 1'b1;
         s.bytes[0] = (val[0] && !val[1]) ? DIR_UP :
                      (!val[0] && val[1]) ? DIR_DOWN : DIR_VMID;
         s.bytes[1] = (val[2] && !val[3]) ? DIR_LEFT :
                      (!val[2] && val[3]) ? DIR_RIGHT : DIR_HMID;
      end
      if ((grp & GRP_COLOR) != 12'd0) begin
         s.mask[2]  = 1'b1;
         s.bytes[2] = COLOR_BASE | {4'd0, val[4], val[5], val[6], val[7]};
      end
      if ((grp & GRP_KEY) != 12'd0) begin
         if (val[11:8] == 4'd0) begin
            s.mask[3]  = 1'b1;
            s.bytes[3] = KEY_NONE;
         end else begin
            s.mask[6:3] = val[11:8];
            s.bytes[3]  = KEY_BASE + 8'd1;
            s.bytes[4]  = KEY_BASE + 8'd2;
            s.bytes[5]  = KEY_BASE + 8'd3;
            s.bytes[6]  = KEY_BASE + 8'd4;
         end
      end
      return s;
   endfunction

   function automatic logic [7:0] checksum(input logic [7:0] b0, input logic [7:0] b1);
      logic [3:0] sum;
      sum = b0[3:0] + b1[3:0] + 4'hF;
      return {4'd0, sum} ^ CSUM_XOR;
   endfunction

endpackage

FILE: src/jsp_ram.sv
module jsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/jsp_push_unit.sv
module jsp_push_unit import jsp_pkg::*; #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                          en,
   input  logic                          empty,
   input  logic [$clog2(FIFO_DEPTH)-1:0] head,
   input  logic [$clog2(FIFO_DEPTH)-1:0] tail,
   output logic [$clog2(FIFO_DEPTH)-1:0] head_next,
   output push_res_type                  res
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   logic full;

   always_comb begin
      full          = !empty && (head == tail);
      res.was_empty = en && empty;
      res.overflow  = en && full;
      res.write     = en && !full;
      head_next     = (head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head + PTR_W'(1);
   end

endmodule

FILE: src/joystick_serial_protocol_engine.sv
// Two-pad serial game-controller engine. Raise start with an event while busy is low; the
// item is taken at that edge and busy stays high until the result is ready. Exactly one
// result follows each item, shown for a single cycle with rsp_strobe and never held, so
// the receiver must take it then. The single-byte push unit writes one FIFO byte per cycle
// (up to seven bytes for a button encode), and a transmit slot also passes through the
// registered FIFO memory read before its pushes and the request update after them.
module joystick_serial_protocol_engine import jsp_pkg::*; #(
   parameter int FIFO_DEPTH = 16,
   parameter int NUM_PADS   = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic        req_controller,
   input  logic [11:0] req_buttons,
   input  logic [11:0] req_changed_buttons,
   input  logic [7:0]  req_rx_data,
   input  logic        req_select_level,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_fifo_empty,
   output logic        rsp_request_line,
   output logic        rsp_irq_pulse,
   output logic [3:0]  rsp_led_status,
   output logic        rsp_overflow
);

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int PAD_W  = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
   localparam int MEM_D  = NUM_PADS * FIFO_DEPTH;
   localparam int ADDR_W = $clog2(MEM_D);
   localparam logic ONE_PAD = (NUM_PADS == 1);

   state_type state_ff, state_in;

   op_type      op_ff, op_in;
   logic        ctrl_ff, ctrl_in;
   logic [11:0] btn_ff, btn_in;
   logic [11:0] chg_ff, chg_in;
   logic [7:0]  rx_ff, rx_in;
   logic        lvl_ff, lvl_in;

   logic        irq_ff, irq_in;
   logic        ovf_ff, ovf_in;
   logic [7:0]  tx_ff, tx_in;
   slots_type   slots_ff, slots_in;

   logic [PTR_W-1:0] head_ff    [NUM_PADS];
   logic [PTR_W-1:0] head_in    [NUM_PADS];
   logic [PTR_W-1:0] tail_ff    [NUM_PADS];
   logic [PTR_W-1:0] tail_in    [NUM_PADS];
   logic             empty_ff   [NUM_PADS];
   logic             empty_in   [NUM_PADS];
   logic             sending_ff [NUM_PADS];
   logic             sending_in [NUM_PADS];
   logic             reqlvl_ff  [NUM_PADS];
   logic             reqlvl_in  [NUM_PADS];
   logic             sel_ff     [NUM_PADS];
   logic             sel_in     [NUM_PADS];
   logic             link_ff    [NUM_PADS];
   logic             link_in    [NUM_PADS];
   logic [11:0]      stale_ff   [NUM_PADS];
   logic [11:0]      stale_in   [NUM_PADS];
   logic [7:0]       hb0_ff     [NUM_PADS];
   logic [7:0]       hb0_in     [NUM_PADS];
   logic [7:0]       hb1_ff     [NUM_PADS];
   logic [7:0]       hb1_in     [NUM_PADS];
   logic [3:0]       led_ff     [NUM_PADS];
   logic [3:0]       led_in     [NUM_PADS];

   logic        strobe_ff, strobe_in;
   logic [7:0]  o_tx_ff, o_tx_in;
   logic        o_empty_ff, o_empty_in;
   logic        o_req_ff, o_req_in;
   logic        o_irq_ff, o_irq_in;
   logic [3:0]  o_led_ff, o_led_in;
   logic        o_ovf_ff, o_ovf_in;

   logic              pad_ok;
   logic [PAD_W-1:0]  pad;
   logic [ADDR_W-1:0] base_addr;
   logic              accept;
   logic              handshake;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   logic [PTR_W-1:0]  push_head_next;
   push_res_type      push_res;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign pad_ok    = !(ONE_PAD && ctrl_ff);
   assign pad       = pad_ok ? PAD_W'(ctrl_ff) : '0;
   assign base_addr = ADDR_W'(ADDR_W'(pad) * ADDR_W'(FIFO_DEPTH));
   assign handshake = (rx_ff[7:4] == RX_HS_FIRST) || (rx_ff[7:4] == RX_HS_NEXT);

   jsp_ram #(
      .WIDTH (8),
      .DEPTH (MEM_D)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (slots_ff.bytes[0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   jsp_push_unit #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_push (
      .en        ((state_ff == ST_PUSH) && pad_ok && slots_ff.mask[0]),
      .empty     (empty_ff[pad]),
      .head      (head_ff[pad]),
      .tail      (tail_ff[pad]),
      .head_next (push_head_next),
      .res       (push_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!pad_ok) begin
               state_in = ST_DONE;
            end else begin
               unique case (op_ff)
                  OP_BUTTONS:
                     state_in = (link_ff[pad] && empty_ff[pad]) ? ST_PUSH : ST_DONE;
                  OP_RX_BYTE:      state_in = handshake ? ST_PUSH : ST_DONE;
                  OP_TX_SLOT:      state_in = ST_POP;
                  OP_REQ_TIMEOUT:  state_in = empty_ff[pad] ? ST_DONE : ST_PUSH;
                  OP_IDLE_TIMEOUT: state_in = ST_PUSH;
                  default:         state_in = ST_DONE;
               endcase
            end
         end
         ST_POP: state_in = ST_PUSH;
         ST_PUSH: begin
            if (slots_ff.mask[NUM_SLOTS-1:1] == '0) begin
               state_in = (op_ff == OP_TX_SLOT) ? ST_POST : ST_DONE;
            end
         end
         ST_POST: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic [PTR_W-1:0] tail_next;
      logic             now_empty;

      op_in    = op_ff;
      ctrl_in  = ctrl_ff;
      btn_in   = btn_ff;
      chg_in   = chg_ff;
      rx_in    = rx_ff;
      lvl_in   = lvl_ff;
      irq_in   = irq_ff;
      ovf_in   = ovf_ff;
      tx_in    = tx_ff;
      slots_in = slots_ff;

      head_in    = head_ff;
      tail_in    = tail_ff;
      empty_in   = empty_ff;
      sending_in = sending_ff;
      reqlvl_in  = reqlvl_ff;
      sel_in     = sel_ff;
      link_in    = link_ff;
      stale_in   = stale_ff;
      hb0_in     = hb0_ff;
      hb1_in     = hb1_ff;
      led_in     = led_ff;

      strobe_in  = 1'b0;
      o_tx_in    = o_tx_ff;
      o_empty_in = o_empty_ff;
      o_req_in   = o_req_ff;
      o_irq_in   = o_irq_ff;
      o_led_in   = o_led_ff;
      o_ovf_in   = o_ovf_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = base_addr + ADDR_W'(head_ff[pad]);
      ram_rd_en   = 1'b0;
      ram_rd_addr = base_addr + ADDR_W'(tail_ff[pad]);

      tail_next = (tail_ff[pad] == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff[pad] + PTR_W'(1);
      now_empty = (head_ff[pad] == tail_next);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_operation);
               ctrl_in  = req_controller;
               btn_in   = req_buttons;
               chg_in   = req_changed_buttons;
               rx_in    = req_rx_data;
               lvl_in   = req_select_level;
               irq_in   = 1'b0;
               ovf_in   = 1'b0;
               tx_in    = '0;
               slots_in = '0;
            end
         end
         ST_DECODE: begin
            if (pad_ok) begin
               unique case (op_ff)
                  OP_BUTTONS: begin
                     if (!link_ff[pad]) begin
                        if (!reqlvl_ff[pad]) begin
                           irq_in = 1'b1;
                        end
                        reqlvl_in[pad] = 1'b1;
                     end else if (!empty_ff[pad]) begin
                        stale_in[pad] = stale_ff[pad] | btn_ff;
                     end else begin
                        slots_in = encode_slots(chg_ff, btn_ff);
                     end
                  end
                  OP_RX_BYTE: begin
                     if (handshake) begin
                        hb0_in[pad] = (rx_ff[7:4] == RX_HS_FIRST) ? 8'd0 : hb1_ff[pad];
                        hb1_in[pad] = rx_ff;
                        slots_in.mask[0]  = 1'b1;
                        slots_in.bytes[0] = checksum(
                           (rx_ff[7:4] == RX_HS_FIRST) ? 8'd0 : hb1_ff[pad], rx_ff);
                     end
                     if (rx_ff[7:4] == RX_LED) begin
                        led_in[pad] = rx_ff[3:0];
                     end
                  end
                  OP_TX_SLOT: begin
                     ram_rd_en = !empty_ff[pad];
                  end
                  OP_REQ_TIMEOUT: begin
                     if (!empty_ff[pad]) begin
                        head_in[pad]  = '0;
                        tail_in[pad]  = '0;
                        empty_in[pad] = 1'b1;
                        if (link_ff[pad]) begin
                           link_in[pad] = 1'b0;
                           hb0_in[pad]  = '0;
                           hb1_in[pad]  = '0;
                        end
                        slots_in.mask[0]  = 1'b1;
                        slots_in.bytes[0] = LINK_RESET;
                     end
                  end
                  OP_IDLE_TIMEOUT: begin
                     slots_in.mask[0]  = 1'b1;
                     slots_in.bytes[0] = LINK_RESET;
                  end
                  OP_SELECT: begin
                     if (sel_ff[pad] != lvl_ff) begin
                        if (lvl_ff && !empty_ff[pad] && !sending_ff[pad]) begin
                           sending_in[pad] = 1'b1;
                        end
                        sel_in[pad] = lvl_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            if (!empty_ff[pad]) begin
               tx_in         = ram_rd_data;
               tail_in[pad]  = tail_next;
               empty_in[pad] = now_empty;
            end
            if (empty_ff[pad] || now_empty) begin
               slots_in      = encode_slots(stale_ff[pad], stale_ff[pad]);
               link_in[pad]  = 1'b1;
               stale_in[pad] = '0;
            end
         end
         ST_PUSH: begin
            if (push_res.overflow) begin
               ovf_in = 1'b1;
            end
            if (push_res.write) begin
               ram_wr_en     = 1'b1;
               head_in[pad]  = push_head_next;
               empty_in[pad] = 1'b0;
            end
            if (push_res.was_empty) begin
               if (!reqlvl_ff[pad]) begin
                  irq_in = 1'b1;
               end
               reqlvl_in[pad] = 1'b1;
               if (sel_ff[pad]) begin
                  sending_in[pad] = 1'b1;
               end
            end
            slots_in.bytes = {8'd0, slots_ff.bytes[NUM_SLOTS-1:1]};
            slots_in.mask  = {1'b0, slots_ff.mask[NUM_SLOTS-1:1]};
         end
         ST_POST: begin
            if (empty_ff[pad]) begin
               sending_in[pad] = 1'b0;
               if (reqlvl_ff[pad]) begin
                  irq_in = 1'b1;
               end
               reqlvl_in[pad] = 1'b0;
            end else if (!sel_ff[pad]) begin
               sending_in[pad] = 1'b0;
            end
         end
         ST_DONE: begin
            strobe_in  = 1'b1;
            o_tx_in    = pad_ok ? tx_ff : '0;
            o_empty_in = pad_ok && empty_ff[pad];
            o_req_in   = pad_ok && reqlvl_ff[pad];
            o_irq_in   = pad_ok && irq_ff;
            o_led_in   = pad_ok ? led_ff[pad] : '0;
            o_ovf_in   = pad_ok && ovf_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_PADS; i++) begin
            head_ff[i]    <= '0;
            tail_ff[i]    <= '0;
            empty_ff[i]   <= 1'b1;
            sending_ff[i] <= 1'b0;
            reqlvl_ff[i]  <= 1'b0;
            sel_ff[i]     <= 1'b0;
            link_ff[i]    <= 1'b0;
            stale_ff[i]   <= '0;
            hb0_ff[i]     <= '0;
            hb1_ff[i]     <= '0;
            led_ff[i]     <= '0;
         end
      end else begin
         state_ff   <= state_in;
         strobe_ff  <= strobe_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         empty_ff   <= empty_in;
         sending_ff <= sending_in;
         reqlvl_ff  <= reqlvl_in;
         sel_ff     <= sel_in;
         link_ff    <= link_in;
         stale_ff   <= stale_in;
         hb0_ff     <= hb0_in;
         hb1_ff     <= hb1_in;
         led_ff     <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ctrl_ff    <= ctrl_in;
      btn_ff     <= btn_in;
      chg_ff     <= chg_in;
      rx_ff      <= rx_in;
      lvl_ff     <= lvl_in;
      irq_ff     <= irq_in;
      ovf_ff     <= ovf_in;
      tx_ff      <= tx_in;
      slots_ff   <= slots_in;
      o_tx_ff    <= o_tx_in;
      o_empty_ff <= o_empty_in;
      o_req_ff   <= o_req_in;
      o_irq_ff   <= o_irq_in;
      o_led_ff   <= o_led_in;
      o_ovf_ff   <= o_ovf_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_tx_byte      = o_tx_ff;
   assign rsp_fifo_empty   = o_empty_ff;
   assign rsp_request_line = o_req_ff;
   assign rsp_irq_pulse    = o_irq_ff;
   assign rsp_led_status   = o_led_ff;
   assign rsp_overflow     = o_ovf_ff;

endmodule

FILE: tb/joystick_serial_protocol_engine_checker.sv
`timescale 1ns / 1ps

module joystick_serial_protocol_engine_checker import jsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_operation,
   input  logic        req_controller,
   input  logic [11:0] req_buttons,
   input  logic [11:0] req_changed_buttons,
   input  logic [7:0]  req_rx_data,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_fifo_empty,
   input  logic        rsp_request_line,
   input  logic        rsp_irq_pulse,
   input  logic [3:0]  rsp_led_status,
   input  logic        rsp_overflow,
   output int          fail_count,
   output int          pending_count
);

   typedef struct {
      logic [7:0] tx_byte;
      logic       fifo_empty;
      logic       request_line;
      logic       irq_pulse;
      logic [3:0] led_status;
      logic       overflow;
   } pad_status_type;

   pad_status_type expected_status_q[$];
   int             result_count;

   logic [7:0]  pad_fifo [2][16];
   logic [3:0]  wr_ptr [2];
   logic [3:0]  rd_ptr [2];
   bit          fifo_empty [2];
   bit          req_level [2];
   bit          link_up [2];
   logic [11:0] stale [2];
   logic [7:0]  hs_prev [2];
   logic [7:0]  hs_last [2];
   logic [3:0]  led [2];
   bit          irq_seen;
   bit          dropped;

   task automatic report_error(input string msg);
      $display("[%0t] result %0d: %s", $realtime, result_count, msg);
      fail_count++;
   endtask

   function automatic void clear_pads();
      for (int p = 0; p < 2; p++) begin
         wr_ptr[p] = '0;
         rd_ptr[p] = '0;
         fifo_empty[p] = 1'b1;
         req_level[p] = 1'b0;
         link_up[p] = 1'b0;
         stale[p] = '0;
         hs_prev[p] = '0;
         hs_last[p] = '0;
         led[p] = '0;
      end
   endfunction

   function automatic void set_request(input int p, input bit level);
      if (req_level[p] != level) begin
         irq_seen = 1'b1;
         req_level[p] = level;
      end
   endfunction

   function automatic void queue_byte(input int p, input logic [7:0] value);
      bit was_empty;
      was_empty = fifo_empty[p];
      if (!fifo_empty[p] && wr_ptr[p] == rd_ptr[p]) begin
         dropped = 1'b1;
      end else begin
         pad_fifo[p][wr_ptr[p]] = value;
         wr_ptr[p] = wr_ptr[p] + 4'd1;
         fifo_empty[p] = 1'b0;
      end
      if (was_empty) set_request(p, 1'b1);
   endfunction

   function automatic logic [7:0] pop_byte(input int p);
      logic [7:0] value;
      if (fifo_empty[p]) return 8'h00;
      value = pad_fifo[p][rd_ptr[p]];
      rd_ptr[p] = rd_ptr[p] + 4'd1;
      fifo_empty[p] = (wr_ptr[p] == rd_ptr[p]);
      return value;
   endfunction

   function automatic void encode_buttons(input int p, input logic [11:0] grp,
                                          input logic [11:0] val);
      if ((grp & GRP_DIR) != 12'd0) begin
         queue_byte(p, (val[0] && !val[1]) ? DIR_UP :
                       (!val[0] && val[1]) ? DIR_DOWN : DIR_VMID);
         queue_byte(p, (val[2] && !val[3]) ? DIR_LEFT :
                       (!val[2] && val[3]) ? DIR_RIGHT : DIR_HMID);
      end
      if ((grp & GRP_COLOR) != 12'd0)
         queue_byte(p, COLOR_BASE | {4'd0, val[4], val[5], val[6], val[7]});
      if ((grp & GRP_KEY) != 12'd0) begin
         for (int k = 0; k < 4; k++)
            if (val[8+k]) queue_byte(p, KEY_BASE + 8'(k + 1));
         if (val[11:8] == 4'd0) queue_byte(p, KEY_NONE);
      end
   endfunction

   function automatic pad_status_type predict_pad_status(input logic [2:0] op, input int p,
                                                         input logic [11:0] btn,
                                                         input logic [11:0] chg,
                                                         input logic [7:0] rx);
      pad_status_type st;
      logic [3:0]     sum;
      irq_seen = 1'b0;
      dropped = 1'b0;
      st.tx_byte = 8'h00;
      case (op)
         OP_BUTTONS: begin
            if (!link_up[p]) set_request(p, 1'b1);
            else if (!fifo_empty[p]) stale[p] |= btn;
            else encode_buttons(p, chg, btn);
         end
         OP_RX_BYTE: begin
            if (rx[7:4] == RX_HS_FIRST || rx[7:4] == RX_HS_NEXT) begin
               hs_prev[p] = (rx[7:4] == RX_HS_FIRST) ? 8'h00 : hs_last[p];
               hs_last[p] = rx;
               sum = hs_prev[p][3:0] + hs_last[p][3:0] + 4'hF;
               queue_byte(p, {4'd0, sum} ^ CSUM_XOR);
            end
            if (rx[7:4] == RX_LED) led[p] = rx[3:0];
         end
         OP_TX_SLOT: begin
            st.tx_byte = pop_byte(p);
            if (fifo_empty[p]) begin
               encode_buttons(p, stale[p], stale[p]);
               link_up[p] = 1'b1;
               stale[p] = '0;
            end
            if (fifo_empty[p]) set_request(p, 1'b0);
         end
         OP_REQ_TIMEOUT: begin
            if (!fifo_empty[p]) begin
               wr_ptr[p] = '0;
               rd_ptr[p] = '0;
               fifo_empty[p] = 1'b1;
               if (link_up[p]) begin
                  link_up[p] = 1'b0;
                  hs_prev[p] = '0;
                  hs_last[p] = '0;
               end
               queue_byte(p, LINK_RESET);
            end
         end
         OP_IDLE_TIMEOUT: queue_byte(p, LINK_RESET);
         // select only steers the send flag, which no result shows
         default: ;
      endcase
      st.fifo_empty = fifo_empty[p];
      st.request_line = req_level[p];
      st.irq_pulse = irq_seen;
      st.led_status = led[p];
      st.overflow = dropped;
      return st;
   endfunction

   always @(posedge clock) begin
      pad_status_type want;
      if (reset) begin
         clear_pads();
         expected_status_q.delete();
         result_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_status_q.size() == 0) begin
               report_error("result with no item outstanding");
            end else begin
               want = expected_status_q.pop_front();
               if (rsp_tx_byte !== want.tx_byte)
                  report_error($sformatf("tx_byte %h, want %h", rsp_tx_byte, want.tx_byte));
               if (rsp_fifo_empty !== want.fifo_empty)
                  report_error($sformatf("fifo_empty %b, want %b", rsp_fifo_empty,
                                         want.fifo_empty));
               if (rsp_request_line !== want.request_line)
                  report_error($sformatf("request_line %b, want %b", rsp_request_line,
                                         want.request_line));
               if (rsp_irq_pulse !== want.irq_pulse)
                  report_error($sformatf("irq_pulse %b, want %b", rsp_irq_pulse,
                                         want.irq_pulse));
               if (rsp_led_status !== want.led_status)
                  report_error($sformatf("led_status %h, want %h", rsp_led_status,
                                         want.led_status));
               if (rsp_overflow !== want.overflow)
                  report_error($sformatf("overflow %b, want %b", rsp_overflow,
                                         want.overflow));
            end
            result_count++;
         end
         if (start && !busy)
            expected_status_q.push_back(predict_pad_status(req_operation,
                                                           int'(req_controller),
                                                           req_buttons,
                                                           req_changed_buttons,
                                                           req_rx_data));
      end
      pending_count <= expected_status_q.size();
   end

endmodule

FILE: tb/joystick_serial_protocol_engine_tb.sv
`timescale 1ns / 1ps

module joystick_serial_protocol_engine_tb import jsp_pkg::*; ();

   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam int         RANDOM_ITEMS = 450;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic        req_controller = 1'b0;
   logic [11:0] req_buttons = '0;
   logic [11:0] req_changed_buttons = '0;
   logic [7:0]  req_rx_data = '0;
   logic        req_select_level = 1'b0;
   logic        rsp_strobe;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_fifo_empty;
   logic        rsp_request_line;
   logic        rsp_irq_pulse;
   logic [3:0]  rsp_led_status;
   logic        rsp_overflow;
   int          fail_count;
   int          pending_count;

   bit          idle_on = 1'b1;
   int          item_count = 0;

   always #4 clock = ~clock;

   joystick_serial_protocol_engine i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_controller      (req_controller),
      .req_buttons         (req_buttons),
      .req_changed_buttons (req_changed_buttons),
      .req_rx_data         (req_rx_data),
      .req_select_level    (req_select_level),
      .rsp_strobe          (rsp_strobe),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_fifo_empty      (rsp_fifo_empty),
      .rsp_request_line    (rsp_request_line),
      .rsp_irq_pulse       (rsp_irq_pulse),
      .rsp_led_status      (rsp_led_status),
      .rsp_overflow        (rsp_overflow)
   );

   joystick_serial_protocol_engine_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_controller      (req_controller),
      .req_buttons         (req_buttons),
      .req_changed_buttons (req_changed_buttons),
      .req_rx_data         (req_rx_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_fifo_empty      (rsp_fifo_empty),
      .rsp_request_line    (rsp_request_line),
      .rsp_irq_pulse       (rsp_irq_pulse),
      .rsp_led_status      (rsp_led_status),
      .rsp_overflow        (rsp_overflow),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   task automatic send_item(input logic [2:0] op, input logic pad, input logic [11:0] btn,
                            input logic [11:0] chg, input logic [7:0] rx,
                            input logic sel);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         if (idle_on && $urandom_range(99) < 18) begin
            start <= 1'b0;
            @(posedge clock);
         end else begin
            start <= 1'b1;
            req_operation <= op;
            req_controller <= pad;
            req_buttons <= btn;
            req_changed_buttons <= chg;
            req_rx_data <= rx;
            req_select_level <= sel;
            @(posedge clock);
            taken = !busy;
         end
      end
      item_count++;
   endtask

   function automatic logic [7:0] pick_rx();
      logic [3:0] lo;
      lo = 4'($urandom_range(15));
      case ($urandom_range(9))
         0, 1, 2: return {RX_HS_FIRST, lo};
         3, 4, 5: return {RX_HS_NEXT, lo};
         6, 7:    return {RX_LED, lo};
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [2:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 30) return OP_BUTTONS;
      if (r < 50) return OP_RX_BYTE;
      if (r < 78) return OP_TX_SLOT;
      if (r < 83) return OP_REQ_TIMEOUT;
      if (r < 88) return OP_IDLE_TIMEOUT;
      if (r < 95) return OP_SELECT;
      return $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
   endfunction

   task automatic send_rand(input logic [2:0] op, input logic pad);
      send_item(op, pad, 12'($urandom_range(4095)),
                ($urandom_range(3) == 0) ? 12'hFFF : 12'($urandom_range(4095)),
                pick_rx(), 1'($urandom_range(1)));
   endtask

   initial begin
      int   base;
      int   r;
      logic pad;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_UNUSED_HI, 1'b0, 12'hFFF, 12'hFFF, 8'hFF, 1'b1);
      send_item(OP_UNUSED_LO, 1'b1, 12'h000, 12'h000, 8'h00, 1'b0);
      send_item(OP_BUTTONS, 1'b1, 12'hFFF, 12'hFFF, 8'h00, 1'b0);
      send_item(OP_TX_SLOT, 1'b0, 12'h000, 12'h000, 8'h00, 1'b0);
      send_item(OP_BUTTONS, 1'b0, 12'h0F5, 12'hFFF, 8'h00, 1'b0);
      send_item(OP_BUTTONS, 1'b0, 12'hFFF, 12'h000, 8'h00, 1'b0);
      send_item(OP_SELECT, 1'b0, 12'h000, 12'h000, 8'h00, 1'b1);
      send_item(OP_SELECT, 1'b0, 12'h000, 12'h000, 8'h00, 1'b1);
      repeat (4) send_item(OP_TX_SLOT, 1'b0, 12'h000, 12'h000, 8'h00, 1'b0);
      send_item(OP_RX_BYTE, 1'b0, 12'h000, 12'h000, {RX_HS_FIRST, 4'hA}, 1'b0);
      send_item(OP_RX_BYTE, 1'b0, 12'h000, 12'h000, {RX_HS_NEXT, 4'h3}, 1'b0);
      send_item(OP_RX_BYTE, 1'b0, 12'h000, 12'h000, {RX_LED, 4'hF}, 1'b0);
      send_item(OP_RX_BYTE, 1'b0, 12'h000, 12'h000, 8'h00, 1'b0);
      send_item(OP_RX_BYTE, 1'b1, 12'h000, 12'h000, 8'hFF, 1'b0);
      send_item(OP_REQ_TIMEOUT, 1'b0, 12'h000, 12'h000, 8'h00, 1'b0);
      send_item(OP_REQ_TIMEOUT, 1'b1, 12'h000, 12'h000, 8'h00, 1'b0);
      send_item(OP_IDLE_TIMEOUT, 1'b1, 12'h000, 12'h000, 8'h00, 1'b0);
      send_item(OP_BUTTONS, 1'b0, 12'h00A, 12'h00A, 8'h00, 1'b0);
      send_item(OP_TX_SLOT, 1'b1, 12'h000, 12'h000, 8'h00, 1'b0);
      send_item(OP_SELECT, 1'b0, 12'h000, 12'h000, 8'h00, 1'b0);

      base = item_count;
      while (item_count - base < RANDOM_ITEMS) begin
         idle_on = !(item_count - base >= 150 && item_count - base < 260);
         pad = 1'($urandom_range(1));
         r = $urandom_range(99);
         if (r < 55) begin
            send_rand(pick_op(), pad);
         end else if (r < 70) begin
            repeat ($urandom_range(20, 8))
               send_rand(($urandom_range(3) == 0) ? OP_IDLE_TIMEOUT : OP_RX_BYTE, pad);
         end else if (r < 85) begin
            repeat ($urandom_range(18, 1)) send_rand(OP_TX_SLOT, pad);
         end else if (r < 95) begin
            send_rand(OP_TX_SLOT, pad);
            repeat ($urandom_range(3, 1)) send_rand(OP_BUTTONS, pad);
            repeat ($urandom_range(12, 1)) send_rand(OP_TX_SLOT, pad);
         end else begin
            send_rand(OP_SELECT, pad);
            send_rand(OP_REQ_TIMEOUT, pad);
         end
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
